### src/multilevel_feedback_queue_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define MFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset.
`define MFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mfq_pkg.sv
// Shared types, codes and helpers of the feedback queue scheduler.
`default_nettype none
package mfq_pkg;

  localparam int unsigned MfqMaxLevels = 8;
  localparam int unsigned MfqLevelDepth = 16;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] rem;
  } job_entry_t;

  typedef enum logic [2:0] {
    EV_ARRIVED  = 3'd0,
    EV_STARTED  = 3'd1,
    EV_FINISHED = 3'd2,
    EV_DEMOTED  = 3'd3,
    EV_REJECTED = 3'd4
  } event_kind_e;

  typedef enum logic [0:0] {
    CMD_ARRIVAL = 1'b0,
    CMD_TICK    = 1'b1
  } command_e;

  typedef enum logic [0:0] {
    REG_LEVEL_COUNT  = 1'b0,
    REG_BASE_QUANTUM = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SEL     = 4'b0010,
    ST_READ    = 4'b0100,
    ST_CONSUME = 4'b1000
  } state_e;

  // Slice length of a level: base (zero acts as one) shifted left by the level.
  function automatic logic [15:0] quantum_of(input logic [7:0] base, input logic [2:0] lvl);
    logic [7:0] b;
    b = (base == 8'd0) ? 8'd1 : base;
    return {8'd0, b} << lvl;
  endfunction

endpackage
`default_nettype wire

### src/mfq_store.sv
// Job memory: one circular queue region per level, synchronous read.
`default_nettype none
module mfq_store
  import mfq_pkg::*;
#(
  parameter int unsigned Depth = MfqMaxLevels * MfqLevelDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire job_entry_t       wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output job_entry_t            rd_data_o
);

  job_entry_t mem_q [Depth];
  job_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

### src/multilevel_feedback_queue_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
//
// channel  direction  handshake               payload
// s_axis   in         tvalid/tready           tuser=command, tdata=job_id,burst_length
// m_axis   out        tvalid/tready, tlast    tuser=event_kind, tdata=job,level,rem,time
// cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data (always ready)
//
// Arrivals are answered from idle; a tick goes to consume if a job runs, else to select.
// A tick that starts a job passes select, read and consume, and a finish or demotion
// restarts one through select and read; each start waits on one read of the job memory.
// Reset clears pointers, counts and run state at once; the job memory needs no clearing.
// Each result sits in the output register; the sequencer holds while that register is full.
`default_nettype none
module multilevel_feedback_queue_scheduler
  import mfq_pkg::*;
#(
  parameter int unsigned MAX_LEVELS  = MfqMaxLevels,
  parameter int unsigned LEVEL_DEPTH = MfqLevelDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // s_axis
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // [7:0] job_id, [23:8] burst_length
  input  wire logic [0:0]  s_axis_tuser_i,  // [0] command
  // m_axis
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,  // [7:0] event_job, [10:8] event_level,
                                            // [26:11] remaining_units, [58:27] event_time
  output logic [2:0]       m_axis_tuser_o,  // [2:0] event_kind
  output logic             m_axis_tlast_o,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned PW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned OW = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned Depth = MAX_LEVELS * LEVEL_DEPTH;
  localparam int unsigned AW = $clog2(Depth);

  // Queue bookkeeping per level
  logic [PW-1:0] head_q [MAX_LEVELS];
  logic [PW-1:0] head_d [MAX_LEVELS];
  logic [PW-1:0] tail_q [MAX_LEVELS];
  logic [PW-1:0] tail_d [MAX_LEVELS];
  logic [OW-1:0] occ_q  [MAX_LEVELS];
  logic [OW-1:0] occ_d  [MAX_LEVELS];

  state_e      state_q, state_d;
  logic        running_q, running_d;
  logic [2:0]  run_lvl_q, run_lvl_d;
  logic [15:0] slice_q, slice_d;
  logic [31:0] tick_q, tick_d;
  logic [7:0]  run_id_q, run_id_d;
  logic [15:0] run_rem_q, run_rem_d;
  logic        pre_q, pre_d;       // start made before the unit is consumed
  logic [2:0]  sel_lvl_q, sel_lvl_d;
  logic [3:0]  lvl_cnt_q;
  logic [7:0]  base_q;

  // Output register
  logic        out_valid_q;
  event_kind_e out_kind_q;
  logic [7:0]  out_job_q;
  logic [2:0]  out_lvl_q;
  logic [15:0] out_rem_q;
  logic [31:0] out_time_q;
  logic        out_last_q;

  logic        out_free;
  logic        emit;
  event_kind_e ev_kind;
  logic [7:0]  ev_job;
  logic [2:0]  ev_lvl;
  logic [15:0] ev_rem;
  logic [31:0] ev_time;
  logic        ev_last;

  logic          push_en, pop_en;
  logic [LW-1:0] push_lvl, pop_lvl;
  job_entry_t    push_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  job_entry_t    rd_data;

  logic          sel_found;
  logic [LW-1:0] sel_idx;
  logic          any_after;
  logic [3:0]    act_levels;
  logic [LW-1:0] lvl_idx, nxt_idx;
  logic [15:0]   rem_n, slice_n;
  logic          fin, expire, nxt_full;
  logic          fin_pre, exp_pre;
  logic          in_acc;
  logic [7:0]    in_id;
  logic [15:0]   in_burst;

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [PW-1:0] p);
    return AW'(AW'(l) * AW'(LEVEL_DEPTH)) + AW'(p);
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(LEVEL_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign in_id    = s_axis_tdata_i[7:0];
  assign in_burst = s_axis_tdata_i[23:8];
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  // Clamp the active level count to [2, MAX_LEVELS]
  always_comb begin
    if (lvl_cnt_q < 4'd2) begin
      act_levels = 4'd2;
    end else if (lvl_cnt_q > 4'(MAX_LEVELS)) begin
      act_levels = 4'(MAX_LEVELS);
    end else begin
      act_levels = lvl_cnt_q;
    end
  end

  // Highest-priority non-empty level
  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
      if (occ_q[l] != '0) begin
        sel_found = 1'b1;
        sel_idx   = LW'(l);
      end
    end
  end

  // One unit of service for the running job
  assign lvl_idx  = run_lvl_q[LW-1:0];
  assign nxt_idx  = LW'(run_lvl_q + 3'd1);
  assign rem_n    = run_rem_q - 16'd1;
  assign slice_n  = slice_q + 16'd1;
  assign fin      = (rem_n == 16'd0);
  assign expire   = !fin && (({1'b0, run_lvl_q} + 4'd1) < act_levels) &&
                    (slice_n >= quantum_of(base_q, run_lvl_q));
  assign nxt_full = expire && (occ_q[nxt_idx] >= OW'(LEVEL_DEPTH));

  // Does anything remain queued once the running job is popped
  always_comb begin
    any_after = 1'b0;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      if (LW'(l) == lvl_idx) begin
        if (occ_q[l] > OW'(1)) any_after = 1'b1;
      end else if (occ_q[l] != '0) begin
        any_after = 1'b1;
      end
    end
  end

  // Outcome of the first unit of a job just read from memory
  assign fin_pre = (rd_data.rem == 16'd1);
  assign exp_pre = !fin_pre && (({1'b0, sel_lvl_q} + 4'd1) < act_levels) &&
                   (16'd1 >= quantum_of(base_q, sel_lvl_q));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    run_lvl_d = run_lvl_q;
    slice_d   = slice_q;
    tick_d    = tick_q;
    run_id_d  = run_id_q;
    run_rem_d = run_rem_q;
    pre_d     = pre_q;
    sel_lvl_d = sel_lvl_q;
    emit      = 1'b0;
    ev_kind   = EV_ARRIVED;
    ev_job    = '0;
    ev_lvl    = '0;
    ev_rem    = '0;
    ev_time   = tick_q;
    ev_last   = 1'b1;
    push_en   = 1'b0;
    push_lvl  = '0;
    push_data = '0;
    pop_en    = 1'b0;
    pop_lvl   = lvl_idx;
    rd_en     = 1'b0;
    rd_addr   = addr_of(sel_idx, head_q[sel_idx]);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == CMD_ARRIVAL) begin
            emit   = 1'b1;
            ev_job = in_id;
            if (in_burst == 16'd0) begin
              ev_kind = EV_REJECTED;
            end else if (occ_q[0] >= OW'(LEVEL_DEPTH)) begin
              ev_kind = EV_REJECTED;
              ev_rem  = in_burst;
            end else begin
              ev_kind   = EV_ARRIVED;
              ev_rem    = in_burst;
              push_en   = 1'b1;
              push_data = '{id: in_id, rem: in_burst};
            end
          end else if (running_q) begin
            state_d = ST_CONSUME;
          end else begin
            pre_d   = 1'b1;
            state_d = ST_SEL;
          end
        end
      end

      ST_SEL: begin
        if (sel_found) begin
          rd_en     = 1'b1;
          sel_lvl_d = 3'(sel_idx);
          state_d   = ST_READ;
        end else begin
          // idle tick: time still advances
          tick_d  = tick_q + 32'd1;
          state_d = ST_IDLE;
        end
      end

      ST_READ: begin
        if (out_free) begin
          running_d = 1'b1;
          run_lvl_d = sel_lvl_q;
          slice_d   = '0;
          run_id_d  = rd_data.id;
          run_rem_d = rd_data.rem;
          emit      = 1'b1;
          ev_kind   = EV_STARTED;
          ev_job    = rd_data.id;
          ev_lvl    = sel_lvl_q;
          ev_rem    = rd_data.rem;
          ev_last   = pre_q ? !(fin_pre || exp_pre) : 1'b1;
          state_d   = pre_q ? ST_CONSUME : ST_IDLE;
        end
      end

      ST_CONSUME: begin
        if (out_free) begin
          tick_d    = tick_q + 32'd1;
          run_rem_d = rem_n;
          slice_d   = slice_n;
          ev_time   = tick_q + 32'd1;
          ev_job    = run_id_q;
          pre_d     = 1'b0;
          if (fin) begin
            pop_en    = 1'b1;
            running_d = 1'b0;
            emit      = 1'b1;
            ev_kind   = EV_FINISHED;
            ev_lvl    = run_lvl_q;
            ev_last   = !any_after;
            state_d   = any_after ? ST_SEL : ST_IDLE;
          end else if (expire) begin
            // demote to the next level, or back to its own tail if that one is full
            pop_en    = 1'b1;
            push_en   = 1'b1;
            push_lvl  = nxt_full ? lvl_idx : nxt_idx;
            push_data = '{id: run_id_q, rem: rem_n};
            running_d = 1'b0;
            emit      = 1'b1;
            ev_kind   = EV_DEMOTED;
            ev_lvl    = nxt_full ? run_lvl_q : (run_lvl_q + 3'd1);
            ev_rem    = rem_n;
            ev_last   = 1'b0;
            state_d   = ST_SEL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign wr_addr = addr_of(push_lvl, tail_q[push_lvl]);

  // Pointer and occupancy updates; a pop and a push may hit the same level
  always_comb begin
    for (int l = 0; l < MAX_LEVELS; l++) begin
      head_d[l] = head_q[l];
      tail_d[l] = tail_q[l];
      occ_d[l]  = occ_q[l];
      if (pop_en && (pop_lvl == LW'(l))) begin
        head_d[l] = ptr_inc(head_q[l]);
        occ_d[l]  = occ_d[l] - OW'(1);
      end
      if (push_en && (push_lvl == LW'(l))) begin
        tail_d[l] = ptr_inc(tail_q[l]);
        occ_d[l]  = occ_d[l] + OW'(1);
      end
    end
  end

  mfq_store #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (push_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (push_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      run_lvl_q   <= '0;
      slice_q     <= '0;
      tick_q      <= '0;
      pre_q       <= 1'b0;
      lvl_cnt_q   <= 4'd3;
      base_q      <= 8'd2;
      out_valid_q <= 1'b0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        occ_q[l]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      run_lvl_q <= run_lvl_d;
      slice_q   <= slice_d;
      tick_q    <= tick_d;
      pre_q     <= pre_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      occ_q     <= occ_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LEVEL_COUNT:  lvl_cnt_q <= cfg_data_i[3:0];
          REG_BASE_QUANTUM: base_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_id_q  <= run_id_d;
    run_rem_q <= run_rem_d;
    sel_lvl_q <= sel_lvl_d;
    if (emit) begin
      out_kind_q <= ev_kind;
      out_job_q  <= ev_job;
      out_lvl_q  <= ev_lvl;
      out_rem_q  <= ev_rem;
      out_time_q <= ev_time;
      out_last_q <= ev_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {5'd0, out_time_q, out_rem_q, out_lvl_q, out_job_q};

  `include "multilevel_feedback_queue_scheduler_assert.svh"

  `MFQ_ASSERT_NOW(a_run_head_queued, running_q, occ_q[run_lvl_q[LW-1:0]] != '0, "running job not queued")
  `MFQ_ASSERT_NEXT(a_finish_stops, emit && (ev_kind == EV_FINISHED), !running_q, "still running after finish")
  `MFQ_ASSERT_NOW(a_tick_step, !$stable(tick_q), tick_q == $past(tick_q) + 32'd1, "tick count jumped")

endmodule
`default_nettype wire
